FILE: rtl/core/mtnd_pkg.sv
// Package with the shared types, character codes and lookup tables of the note decoder.
`timescale 1ns / 1ps

package mtnd_pkg;

  localparam int NOTE_COUNT_DEFAULT = 24;
  localparam int TABLE_SIZE = 24;
  localparam int INDEX_W = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int SYMBOL_W = 8;
  localparam int PERIOD_W = 12;
  localparam int SOUND_W = 11;
  localparam int REST_W = 9;
  localparam int OFFSET_W = 8;

  localparam logic [SYMBOL_W-1:0] CH_END = 8'h00;
  localparam logic [SYMBOL_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    LEN_1600,
    LEN_800,
    LEN_400,
    LEN_200,
    LEN_100,
    LEN_50
  } len_code_t;

  typedef struct packed {
    logic      hit;
    len_code_t code;
  } len_hit_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] value;
  } semi_hit_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    len_code_t          len;
  } note_cmd_t;

  function automatic len_hit_t length_of(input logic [SYMBOL_W-1:0] c);
    len_hit_t r;
    r.hit = 1'b1;
    r.code = LEN_200;
    unique case (c)
      "1": r.code = LEN_1600;
      "2": r.code = LEN_800;
      "4": r.code = LEN_400;
      "8": r.code = LEN_200;
      "6": r.code = LEN_100;
      "3": r.code = LEN_50;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic semi_hit_t semitone_of(input logic [SYMBOL_W-1:0] c);
    semi_hit_t r;
    r.hit = 1'b1;
    r.value = 5'd0;
    unique case (c)
      "c": r.value = 5'd0;
      "d": r.value = 5'd2;
      "e": r.value = 5'd4;
      "f": r.value = 5'd5;
      "g": r.value = 5'd7;
      "a": r.value = 5'd9;
      "b": r.value = 5'd11;
      "C": r.value = 5'd12;
      "D": r.value = 5'd14;
      "E": r.value = 5'd16;
      "F": r.value = 5'd17;
      "G": r.value = 5'd19;
      "A": r.value = 5'd21;
      "B": r.value = 5'd23;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [PERIOD_W-1:0] period_of(input logic [INDEX_W-1:0] idx);
    logic [PERIOD_W-1:0] p;
    unique case (idx)
      5'd0: p = 12'd3823;
      5'd1: p = 12'd3608;
      5'd2: p = 12'd3405;
      5'd3: p = 12'd3214;
      5'd4: p = 12'd3034;
      5'd5: p = 12'd2864;
      5'd6: p = 12'd2703;
      5'd7: p = 12'd2551;
      5'd8: p = 12'd2408;
      5'd9: p = 12'd2273;
      5'd10: p = 12'd2241;
      5'd11: p = 12'd2025;
      5'd12: p = 12'd1911;
      5'd13: p = 12'd1804;
      5'd14: p = 12'd1703;
      5'd15: p = 12'd1607;
      5'd16: p = 12'd1517;
      5'd17: p = 12'd1432;
      5'd18: p = 12'd1351;
      5'd19: p = 12'd1276;
      5'd20: p = 12'd1204;
      5'd21: p = 12'd1136;
      5'd22: p = 12'd1073;
      5'd23: p = 12'd1066;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

  // Sound time is four fifths of the note length, truncated.
  function automatic logic [SOUND_W-1:0] sound_of(input len_code_t code);
    logic [SOUND_W-1:0] s;
    unique case (code)
      LEN_1600: s = 11'd1280;
      LEN_800: s = 11'd640;
      LEN_400: s = 11'd320;
      LEN_200: s = 11'd160;
      LEN_100: s = 11'd80;
      LEN_50: s = 11'd40;
      default: s = 11'd0;
    endcase
    return s;
  endfunction

  function automatic logic [REST_W-1:0] rest_of(input len_code_t code);
    logic [REST_W-1:0] r;
    unique case (code)
      LEN_1600: r = 9'd320;
      LEN_800: r = 9'd160;
      LEN_400: r = 9'd80;
      LEN_200: r = 9'd40;
      LEN_100: r = 9'd20;
      LEN_50: r = 9'd10;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/melody_text_note_decoder_unit.sv
// Top level of the melody text note decoder: front end, command queue and back end.
// A note letter goes into the command queue, then its lookup is registered onto m_tdata.
// Throughput: one byte per cycle unless the queue is full; one command per cycle unless stalled.
// Bytes that make no note (lengths, offsets, end of song, others) finish in the accepting cycle.
// Reset (synchronous, rst high): length returns to 200 ms, offset to zero, queue and output empty.
`timescale 1ns / 1ps

module melody_text_note_decoder_unit #(
  parameter int NOTE_COUNT = mtnd_pkg::NOTE_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] symbol
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // [11:0] period_us, [22:12] sound_ms, [31:23] rest_ms
);

  logic                queue_full;
  logic                push;
  mtnd_pkg::note_cmd_t push_cmd;
  logic                pop;
  logic                head_valid;
  mtnd_pkg::note_cmd_t head_cmd;

  mtnd_front #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .queue_full(queue_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  mtnd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  mtnd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: rtl/core/mtnd_front.sv
// Front end: takes text bytes, keeps length and offset state, and issues note commands.
`timescale 1ns / 1ps

module mtnd_front #(
  parameter int NOTE_COUNT = mtnd_pkg::NOTE_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mtnd_pkg::SYMBOL_W-1:0] s_tdata,
  input  logic                          queue_full,
  output logic                          push,
  output mtnd_pkg::note_cmd_t           push_cmd
);

  mtnd_pkg::len_code_t             note_len;
  mtnd_pkg::len_code_t             note_len_next;
  logic [mtnd_pkg::OFFSET_W-1:0]   offset;
  logic [mtnd_pkg::OFFSET_W-1:0]   offset_next;
  logic                            s_fire;
  mtnd_pkg::len_hit_t              len_hit;
  mtnd_pkg::semi_hit_t             semi_hit;
  logic [mtnd_pkg::OFFSET_W-1:0]   raw_index;
  logic                            index_ok;

  assign s_tready = !queue_full;
  assign s_fire = s_tvalid && s_tready;

  assign len_hit = mtnd_pkg::length_of(s_tdata);
  assign semi_hit = mtnd_pkg::semitone_of(s_tdata);
  assign raw_index = offset + {{(mtnd_pkg::OFFSET_W - mtnd_pkg::INDEX_W){1'b0}}, semi_hit.value};
  assign index_ok = !raw_index[mtnd_pkg::OFFSET_W-1]
                 && ({1'b0, raw_index} < 9'(mtnd_pkg::TABLE_SIZE))
                 && ({1'b0, raw_index} < 9'(NOTE_COUNT));

  always_comb begin
    note_len_next = note_len;
    offset_next = offset;
    push = 1'b0;
    push_cmd.index = raw_index[mtnd_pkg::INDEX_W-1:0];
    push_cmd.len = note_len;
    if (s_fire) begin
      if (s_tdata == mtnd_pkg::CH_END) begin
        note_len_next = mtnd_pkg::LEN_200;
        offset_next = '0;
      end else if (len_hit.hit) begin
        note_len_next = len_hit.code;
      end else if (s_tdata == mtnd_pkg::CH_PLUS) begin
        offset_next = offset + 8'd1;
      end else if (s_tdata == mtnd_pkg::CH_MINUS) begin
        offset_next = offset - 8'd1;
      end else if (semi_hit.hit) begin
        offset_next = '0;
        push = index_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_len <= mtnd_pkg::LEN_200;
      offset <= '0;
    end else begin
      note_len <= note_len_next;
      offset <= offset_next;
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && s_tdata == mtnd_pkg::CH_END) |=> (offset == '0 && note_len == mtnd_pkg::LEN_200))
    else $error("end of song did not restore defaults");

  a_note_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && semi_hit.hit) |=> (offset == '0))
    else $error("note letter did not clear the offset");

  a_push_in_range: assert property (@(posedge clk) disable iff (rst)
    push |-> (s_fire && push_cmd.index < 5'(mtnd_pkg::TABLE_SIZE)))
    else $error("note command issued out of range or without a transfer");

endmodule

FILE: rtl/core/mtnd_queue.sv
// Short queue of note commands between the front end and the back end.
`timescale 1ns / 1ps

module mtnd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mtnd_pkg::note_cmd_t push_cmd,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output mtnd_pkg::note_cmd_t head_cmd
);

  localparam int PTR_W = (mtnd_pkg::QUEUE_DEPTH > 1) ? $clog2(mtnd_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mtnd_pkg::QUEUE_DEPTH + 1);

  mtnd_pkg::note_cmd_t entries [mtnd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full = (count == CNT_W'(mtnd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(mtnd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(mtnd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(mtnd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/core/mtnd_back.sv
// Back end: looks up the period and timing of a note command and holds the result.
`timescale 1ns / 1ps

module mtnd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  mtnd_pkg::note_cmd_t head_cmd,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata
);

  logic [mtnd_pkg::PERIOD_W-1:0] period;
  logic [mtnd_pkg::SOUND_W-1:0]  sound;
  logic [mtnd_pkg::REST_W-1:0]   rest;

  assign pop = head_valid && (!m_tvalid || m_tready);
  assign m_tdata = {rest, sound, period};

  always_ff @(posedge clk) begin
    if (pop) begin
      period <= mtnd_pkg::period_of(head_cmd.index);
      sound <= mtnd_pkg::sound_of(head_cmd.len);
      rest <= mtnd_pkg::rest_of(head_cmd.len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_pop_loads: assert property (@(posedge clk) disable iff (rst) pop |=> m_tvalid)
    else $error("popped command did not reach the output");

  a_sum_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((12'(sound) + 12'(rest)) * 12'd4 == 12'(sound) * 12'd5
                  || sound == 11'd1280))
    else $error("sound and rest times do not split the length four to one");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !pop)
    else $error("output overwritten while stalled");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the melody text note decoder with driver, monitor and predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int NOTE_COUNT = mtnd_pkg::NOTE_COUNT_DEFAULT;
  localparam int TABLE_SIZE = mtnd_pkg::TABLE_SIZE;
  localparam int SYMBOL_W = mtnd_pkg::SYMBOL_W;
  localparam int PERIOD_W = mtnd_pkg::PERIOD_W;
  localparam int SOUND_W = mtnd_pkg::SOUND_W;
  localparam int REST_W = mtnd_pkg::REST_W;
  localparam int OFFSET_W = mtnd_pkg::OFFSET_W;
  localparam int TEXT_ITEMS = 1550;
  localparam int CALM_TAIL = 150;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DEFAULT_LEN_MS = 200;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SOUND_W-1:0]  sound;
    logic [REST_W-1:0]   rest;
  } tone_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] symbol
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [11:0] period_us, [22:12] sound_ms, [31:23] rest_ms

  logic [SYMBOL_W-1:0] symbol_queue[$];
  tone_t               tone_queue[$];
  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  send_gap = 0;
  int                  stall_left = 0;

  logic [SOUND_W-1:0]  note_len_ms = SOUND_W'(DEFAULT_LEN_MS);
  logic [OFFSET_W-1:0] semi_offset = '0;
  logic [PERIOD_W-1:0] tone_period[0:TABLE_SIZE-1] = '{
    12'd3823, 12'd3608, 12'd3405, 12'd3214, 12'd3034, 12'd2864, 12'd2703, 12'd2551,
    12'd2408, 12'd2273, 12'd2241, 12'd2025, 12'd1911, 12'd1804, 12'd1703, 12'd1607,
    12'd1517, 12'd1432, 12'd1351, 12'd1276, 12'd1204, 12'd1136, 12'd1073, 12'd1066
  };

  melody_text_note_decoder_unit #(.NOTE_COUNT(NOTE_COUNT)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Advances the decoder state by one text byte and queues the tone it sounds, if any.
  task automatic decode_symbol(input logic [SYMBOL_W-1:0] c);
    int                  len_ms;
    int                  semi;
    int                  idx;
    int                  sound;
    logic [OFFSET_W-1:0] raw;
    tone_t               t;
    len_ms = 0;
    semi = -1;
    case (c)
      "1": len_ms = 1600;
      "2": len_ms = 800;
      "4": len_ms = 400;
      "8": len_ms = 200;
      "6": len_ms = 100;
      "3": len_ms = 50;
      default: len_ms = 0;
    endcase
    case (c)
      "c": semi = 0;
      "d": semi = 2;
      "e": semi = 4;
      "f": semi = 5;
      "g": semi = 7;
      "a": semi = 9;
      "b": semi = 11;
      "C": semi = 12;
      "D": semi = 14;
      "E": semi = 16;
      "F": semi = 17;
      "G": semi = 19;
      "A": semi = 21;
      "B": semi = 23;
      default: semi = -1;
    endcase
    if (c == mtnd_pkg::CH_END) begin
      note_len_ms = SOUND_W'(DEFAULT_LEN_MS);
      semi_offset = '0;
    end else if (len_ms != 0) begin
      note_len_ms = SOUND_W'(len_ms);
    end else if (c == mtnd_pkg::CH_PLUS) begin
      semi_offset = semi_offset + 1'b1;
    end else if (c == mtnd_pkg::CH_MINUS) begin
      semi_offset = semi_offset - 1'b1;
    end else if (semi >= 0) begin
      raw = semi_offset + OFFSET_W'(semi);
      semi_offset = '0;
      idx = int'($signed(raw));
      if (idx >= 0 && idx < NOTE_COUNT && idx < TABLE_SIZE) begin
        sound = int'(note_len_ms) * 4 / 5;
        t.period = tone_period[idx];
        t.sound = SOUND_W'(sound);
        t.rest = REST_W'(int'(note_len_ms) - sound);
        tone_queue.push_back(t);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decode_symbol(s_tdata);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (symbol_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 19) - 1;
          s_tvalid <= 1'b0;
        end else if (symbol_queue.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= symbol_queue.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (symbol_queue.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tone_t want;
    tone_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.period = m_tdata[11:0];
      got.sound = m_tdata[22:12];
      got.rest = m_tdata[31:23];
      if (tone_queue.size() == 0) begin
        $error("Unexpected tone transfer: period_us %0d sound_ms %0d rest_ms %0d",
               got.period, got.sound, got.rest);
        mismatches++;
      end else begin
        want = tone_queue.pop_front();
        if (got.period !== want.period) begin
          $error("period_us: expected %0d, got %0d", want.period, got.period);
          mismatches++;
        end
        if (got.sound !== want.sound) begin
          $error("sound_ms: expected %0d, got %0d", want.sound, got.sound);
          mismatches++;
        end
        if (got.rest !== want.rest) begin
          $error("rest_ms: expected %0d, got %0d", want.rest, got.rest);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    string letters;
    string lengths;
    int    counted;
    int    pick;
    int    run;
    logic [SYMBOL_W-1:0] step;
    logic [SYMBOL_W-1:0] directed[$];
    letters = "cdefgabCDEFGAB";
    lengths = "124863";
    counted = 0;

    // Every length and letter, a negative index, an index past the table, stray bytes, song end.
    directed = '{"1", "c", "2", "d", "4", "e", "6", "f", "3", "g", "a", "b", "C", "D",
                 "E", "8", "F", "G", "A", "B", mtnd_pkg::CH_MINUS, "c", mtnd_pkg::CH_PLUS,
                 "B", 8'hFF, 8'h80, "1", mtnd_pkg::CH_END, "a"};
    foreach (directed[i]) symbol_queue.push_back(directed[i]);

    while (counted < TEXT_ITEMS) begin
      pick = $urandom_range(0, 199);
      if (pick == 0) begin
        // A long run of one sign (120 to 260 bytes) drives the offset far out of range and may wrap it.
        run = $urandom_range(120, 260);
        step = $urandom_range(0, 1) ? mtnd_pkg::CH_PLUS : mtnd_pkg::CH_MINUS;
        repeat (run) symbol_queue.push_back(step);
        symbol_queue.push_back(letters[$urandom_range(0, 13)]);
        counted += run + 1;
      end else if (pick < 20) begin
        symbol_queue.push_back(mtnd_pkg::CH_END);
        counted++;
      end else if (pick < 50) begin
        symbol_queue.push_back(SYMBOL_W'($urandom_range(0, 255)));
        counted++;
      end else begin
        if ($urandom_range(0, 1)) begin
          symbol_queue.push_back(lengths[$urandom_range(0, 5)]);
          counted++;
        end
        run = $urandom_range(0, 3);
        repeat (run) symbol_queue.push_back($urandom_range(0, 1) ? mtnd_pkg::CH_PLUS
                                                                 : mtnd_pkg::CH_MINUS);
        symbol_queue.push_back(letters[$urandom_range(0, 13)]);
        counted += run + 1;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (symbol_queue.size() != 0 || s_tvalid || tone_queue.size() != 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
